FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every clock edge once reset is released
`define NS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every clock edge, reset included
`define NS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/nalscan_pkg.sv
// types, codes and helpers for the nal unit scanner
package nalscan_pkg;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       is_last;
    } in_t;

    typedef enum logic [1:0] {
        STATUS_UNIT      = 2'd0,
        STATUS_NO_MDAT   = 2'd1,
        STATUS_SMALL_BOX = 2'd2
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] unit_index;
        logic [31:0] unit_length;
        logic [4:0]  unit_type;
    } out_t;

    typedef struct packed {
        logic valid;
        out_t word;
    } result_t;

    typedef enum logic [3:0] {
        PH_TOP_HDR    = 4'd0,
        PH_TOP_SKIP   = 4'd1,
        PH_MOOF_HDR   = 4'd2,
        PH_MOOF_SKIP  = 4'd3,
        PH_TRAF_HDR   = 4'd4,
        PH_TRAF_SKIP  = 4'd5,
        PH_TRUN_BODY  = 4'd6,
        PH_NAL_PREFIX = 4'd7,
        PH_NAL_TYPE   = 4'd8,
        PH_NAL_BODY   = 4'd9,
        PH_DONE       = 4'd10
    } phase_t;

    localparam logic [31:0] BOX_MDAT = 32'h6D646174;
    localparam logic [31:0] BOX_MOOF = 32'h6D6F6F66;
    localparam logic [31:0] BOX_TRAF = 32'h74726166;
    localparam logic [31:0] BOX_TRUN = 32'h7472756E;

    localparam logic [31:0] MIN_BOX_SIZE    = 32'd8;
    localparam logic [4:0]  HDR_BYTES       = 5'd8;
    localparam logic [4:0]  PREFIX_BYTES    = 5'd4;
    localparam logic [4:0]  TRUN_OFFSET_POS = 5'd16;
    localparam logic [4:0]  TRUN_OFFSET_END = 5'd20;
    localparam logic [1:0]  TRAF_WANTED     = 2'd2;
    localparam int          NAL_TYPE_BITS   = 5;

    function automatic logic in_moof_level(phase_t ph);
        return (ph >= PH_TOP_SKIP) && (ph <= PH_TRUN_BODY);
    endfunction

    function automatic logic in_traf_level(phase_t ph);
        return (ph >= PH_TRAF_HDR) && (ph <= PH_TRUN_BODY);
    endfunction

endpackage

FILE: rtl/nalscan_parser.sv
// box walker and nal unit splitter, one byte per accepted word
module nalscan_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  nalscan_pkg::in_t     src_word,
    output nalscan_pkg::result_t result
);
    import nalscan_pkg::*;

    phase_t      phase_reg,   phase_next;
    logic [63:0] shift_reg,   shift_next;
    logic [4:0]  count_reg,   count_next;
    logic [31:0] top_reg,     top_next;
    logic [31:0] traf_reg,    traf_next;
    logic [31:0] child_reg,   child_next;
    logic [1:0]  seen_reg,    seen_next;
    logic [31:0] offset_reg,  offset_next;
    logic [31:0] walk_reg,    walk_next;
    logic [31:0] left_reg,    left_next;
    logic [31:0] counter_reg, counter_next;

    logic [7:0]  b;
    logic [63:0] sh_col;
    logic [31:0] box_size;
    logic [31:0] box_type;
    logic [31:0] nal_len;
    logic [1:0]  seen_inc;
    result_t     res;

    assign b        = src_word.file_byte;
    assign sh_col   = {shift_reg[55:0], b};
    assign box_size = sh_col[63:32];
    assign box_type = sh_col[31:0];
    assign nal_len  = shift_reg[31:0];
    assign seen_inc = (box_type == BOX_TRAF && seen_reg < TRAF_WANTED) ?
                      seen_reg + 2'd1 : seen_reg;
    assign result   = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_TOP_HDR;
            shift_reg   <= '0;
            count_reg   <= '0;
            top_reg     <= '0;
            traf_reg    <= '0;
            child_reg   <= '0;
            seen_reg    <= '0;
            offset_reg  <= '0;
            walk_reg    <= '0;
            left_reg    <= '0;
            counter_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            shift_reg   <= shift_next;
            count_reg   <= count_next;
            top_reg     <= top_next;
            traf_reg    <= traf_next;
            child_reg   <= child_next;
            seen_reg    <= seen_next;
            offset_reg  <= offset_next;
            walk_reg    <= walk_next;
            left_reg    <= left_next;
            counter_reg <= counter_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        shift_next   = shift_reg;
        count_next   = count_reg;
        top_next     = top_reg;
        traf_next    = traf_reg;
        child_next   = child_reg;
        seen_next    = seen_reg;
        offset_next  = offset_reg;
        walk_next    = walk_reg;
        left_next    = left_reg;
        counter_next = counter_reg;
        res          = '0;

        // parent boxes count down on every byte spent inside them
        if (in_moof_level(phase_reg) && top_reg != '0)
            top_next = top_reg - 32'd1;
        if (in_traf_level(phase_reg) && traf_reg != '0)
            traf_next = traf_reg - 32'd1;

        unique case (phase_reg)
            PH_TOP_HDR, PH_MOOF_HDR, PH_TRAF_HDR:
            begin
                shift_next = sh_col;
                if (count_reg < HDR_BYTES)
                    count_next = count_reg + 5'd1;
                if (count_next == HDR_BYTES)
                begin
                    if (box_size < MIN_BOX_SIZE)
                    begin
                        res.valid       = 1'b1;
                        res.word.status = STATUS_SMALL_BOX;
                        phase_next      = PH_DONE;
                        shift_next      = '0;
                        count_next      = '0;
                    end
                    else if (phase_reg == PH_TOP_HDR)
                    begin
                        shift_next = '0;
                        count_next = '0;
                        if (box_type == BOX_MOOF)
                        begin
                            offset_next = '0;
                            seen_next   = '0;
                            top_next    = box_size - MIN_BOX_SIZE;
                            phase_next  = PH_MOOF_HDR;
                        end
                        else if (box_type == BOX_MDAT)
                        begin
                            if (offset_reg == '0)
                                walk_next = box_size - MIN_BOX_SIZE;
                            else if (offset_reg >= MIN_BOX_SIZE)
                                walk_next = offset_reg - MIN_BOX_SIZE;
                            else
                                walk_next = '0;
                            counter_next = '0;
                            phase_next   = (walk_next == '0) ? PH_DONE : PH_NAL_PREFIX;
                        end
                        else
                        begin
                            top_next   = box_size - MIN_BOX_SIZE;
                            phase_next = PH_TOP_SKIP;
                        end
                    end
                    else if (phase_reg == PH_MOOF_HDR)
                    begin
                        shift_next = '0;
                        count_next = '0;
                        seen_next  = seen_inc;
                        if (box_type == BOX_TRAF && seen_inc == TRAF_WANTED)
                        begin
                            traf_next  = box_size - MIN_BOX_SIZE;
                            phase_next = PH_TRAF_HDR;
                        end
                        else
                        begin
                            child_next = box_size - MIN_BOX_SIZE;
                            phase_next = (child_next == '0) ? PH_MOOF_HDR : PH_MOOF_SKIP;
                        end
                    end
                    else
                    begin
                        shift_next = '0;
                        count_next = '0;
                        if (box_type == BOX_TRUN)
                        begin
                            // trun header already consumed, count from byte eight
                            phase_next = PH_TRUN_BODY;
                            count_next = HDR_BYTES;
                        end
                        else
                        begin
                            child_next = box_size - MIN_BOX_SIZE;
                            phase_next = (child_next == '0) ? PH_TRAF_HDR : PH_TRAF_SKIP;
                        end
                    end
                end
            end
            PH_MOOF_SKIP, PH_TRAF_SKIP:
            begin
                if (child_reg != '0)
                    child_next = child_reg - 32'd1;
                if (child_next == '0)
                begin
                    phase_next = (phase_reg == PH_MOOF_SKIP) ? PH_MOOF_HDR : PH_TRAF_HDR;
                    shift_next = '0;
                    count_next = '0;
                end
            end
            PH_TRUN_BODY:
            begin
                if (count_reg >= TRUN_OFFSET_POS)
                    shift_next = sh_col;
                count_next = count_reg + 5'd1;
                if (count_next >= TRUN_OFFSET_END)
                begin
                    offset_next = shift_next[31:0];
                    phase_next  = PH_TOP_SKIP;
                    shift_next  = '0;
                    count_next  = '0;
                end
            end
            PH_NAL_PREFIX:
            begin
                if (walk_reg != '0)
                    walk_next = walk_reg - 32'd1;
                shift_next = sh_col;
                if (count_reg < PREFIX_BYTES)
                    count_next = count_reg + 5'd1;
                if (count_next == PREFIX_BYTES)
                    phase_next = PH_NAL_TYPE;
            end
            PH_NAL_TYPE:
            begin
                counter_next       = counter_reg + 32'd1;
                res.valid          = 1'b1;
                res.word.status    = STATUS_UNIT;
                res.word.unit_index  = counter_next;
                res.word.unit_length = nal_len;
                res.word.unit_type   = b[NAL_TYPE_BITS-1:0];
                if (walk_reg != '0)
                    walk_next = walk_reg - 32'd1;
                shift_next = '0;
                count_next = '0;
                if (nal_len == '0)
                begin
                    // empty unit: this byte opens the next prefix
                    if (walk_reg != '0)
                    begin
                        phase_next = PH_NAL_PREFIX;
                        shift_next = {56'd0, b};
                        count_next = 5'd1;
                    end
                    else
                        phase_next = PH_DONE;
                end
                else
                begin
                    left_next = nal_len - 32'd1;
                    if (left_next == '0)
                        phase_next = (walk_next == '0) ? PH_DONE : PH_NAL_PREFIX;
                    else
                        phase_next = PH_NAL_BODY;
                end
            end
            PH_NAL_BODY:
            begin
                if (walk_reg != '0)
                    walk_next = walk_reg - 32'd1;
                if (left_reg != '0)
                    left_next = left_reg - 32'd1;
                if (left_next == '0)
                begin
                    phase_next = (walk_next == '0) ? PH_DONE : PH_NAL_PREFIX;
                    shift_next = '0;
                    count_next = '0;
                end
            end
            default:
            begin
            end
        endcase

        // a child cannot outlive its traf or moof
        if (in_traf_level(phase_next) && traf_next == '0)
        begin
            phase_next = PH_TOP_SKIP;
            shift_next = '0;
            count_next = '0;
        end
        if (in_moof_level(phase_next) && top_next == '0)
        begin
            phase_next = PH_TOP_HDR;
            shift_next = '0;
            count_next = '0;
        end

        if (src_word.is_last)
        begin
            if (!res.valid && phase_next <= PH_TRUN_BODY)
            begin
                res             = '0;
                res.valid       = 1'b1;
                res.word.status = STATUS_NO_MDAT;
            end
            phase_next   = PH_TOP_HDR;
            shift_next   = '0;
            count_next   = '0;
            top_next     = '0;
            traf_next    = '0;
            child_next   = '0;
            seen_next    = '0;
            offset_next  = '0;
            walk_next    = '0;
            left_next    = '0;
            counter_next = '0;
        end
    end

endmodule

FILE: rtl/nalscan_out_reg.sv
// result register with stall toward the byte side
module nalscan_out_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  nalscan_pkg::result_t result,
    output logic                 src_stall,
    output logic                 rec_valid,
    input  logic                 rec_stall,
    output nalscan_pkg::out_t    rec_word
);
    import nalscan_pkg::*;

    logic rec_valid_reg, rec_valid_next;
    out_t rec_word_reg;

    // hold the byte side only while a word sits here and is not taken
    assign src_stall = rec_valid_reg && rec_stall;
    assign rec_valid = rec_valid_reg;
    assign rec_word  = rec_word_reg;

    always_comb
    begin
        rec_valid_next = rec_valid_reg;
        if (accept && result.valid)
            rec_valid_next = 1'b1;
        else if (!rec_stall)
            rec_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rec_valid_reg <= 1'b0;
        else
            rec_valid_reg <= rec_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && result.valid)
            rec_word_reg <= result.word;
    end

endmodule

FILE: rtl/fmp4_nal_unit_scanner.sv
// top level of the fragmented mp4 nal unit scanner
//
//  channel  signals                          word
//  src      src_valid  src_stall  src_word   one file byte and its last mark
//  rec      rec_valid  rec_stall  rec_word   one unit record or error status
//
//  one byte is taken per cycle while src is not stalled; a result shows on rec the cycle after its byte
//  all parsing work sits in one level of logic ahead of the state registers
//  rst_n clears the parser to the top-level box header and empties rec
//  src stalls only while a result waits in rec and rec_stall is high
//  after a byte marked last the parser is back at reset for the next file
module fmp4_nal_unit_scanner (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_valid,
    output logic              src_stall,
    input  nalscan_pkg::in_t  src_word,
    output logic              rec_valid,
    input  logic              rec_stall,
    output nalscan_pkg::out_t rec_word
);
    import nalscan_pkg::*;

    logic    accept;
    result_t result;

    assign accept = src_valid && !src_stall;

    nalscan_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .src_word (src_word),
        .result   (result)
    );

    nalscan_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .result    (result),
        .src_stall (src_stall),
        .rec_valid (rec_valid),
        .rec_stall (rec_stall),
        .rec_word  (rec_word)
    );

endmodule

FILE: rtl/nalscan_checker.sv
// port-level checks for the nal unit scanner and their bind
`include "assert_macros.svh"

module nalscan_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              src_valid,
    input logic              src_stall,
    input nalscan_pkg::in_t  src_word,
    input logic              rec_valid,
    input logic              rec_stall,
    input nalscan_pkg::out_t rec_word
);
    import nalscan_pkg::*;

    `NS_ASSERT(a_rec_hold, rec_valid && rec_stall |=> rec_valid && $stable(rec_word), "rec word changed while stalled")

    `NS_ASSERT_ALWAYS(a_stall_only_full, src_stall |-> rec_valid && rec_stall, "src stalled with room in rec")

    `NS_ASSERT(a_rec_from_byte, $rose(rec_valid) |-> $past(src_valid && !src_stall), "rec word without a byte")

    `NS_ASSERT(a_error_zero, rec_valid && rec_word.status != STATUS_UNIT |-> rec_word.unit_index == 32'd0 && rec_word.unit_length == 32'd0 && rec_word.unit_type == 5'd0, "error word carries unit fields")

    // a byte with its last mark and an empty rec should never stall
    `NS_ASSERT(a_last_moves, src_valid && src_word.is_last && !rec_valid |-> !src_stall, "last byte stalled with empty rec")

endmodule

bind fmp4_nal_unit_scanner nalscan_checker u_nalscan_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_word  (src_word),
    .rec_valid (rec_valid),
    .rec_stall (rec_stall),
    .rec_word  (rec_word)
);
